[hw/rtl/infix_to_postfix_converter_defines.svh]
// Assertion macros shared by the RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/itp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package itp_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OP_W        = 2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Operator codes as held on the stack; the upper bit is the precedence.
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  function automatic logic is_blank(input logic [7:0] ch);
    return ch inside {CH_SPACE, CH_TAB, CH_NL};
  endfunction

  function automatic logic is_op(input logic [7:0] ch);
    return ch inside {CH_PLUS, CH_MINUS, CH_MUL, CH_DIV};
  endfunction

  function automatic op_e op_code(input logic [7:0] ch);
    op_e code;
    case (ch)
      CH_PLUS:  code = OP_ADD;
      CH_MINUS: code = OP_SUB;
      CH_MUL:   code = OP_MUL;
      CH_DIV:   code = OP_DIV;
      default:  code = OP_ADD;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] op_char(input op_e code);
    logic [7:0] ch;
    case (code)
      OP_ADD:  ch = CH_PLUS;
      OP_SUB:  ch = CH_MINUS;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      default: ch = CH_PLUS;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/infix_to_postfix_converter.sv]
// An operand request shows on the output the cycle after it is taken, through the
// output register. An operator is accepted, then pops each entry of equal or higher
// precedence and then pushes or drops; a flush is accepted and pops every stacked entry.
// Throughput is set by the single stack RAM port pair: one pop per cycle; output
// stalls hold the controller. Reset clears the stack count, the controller and the
// output valid bit; the stack RAM is not cleared, since only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input request channel
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  wire logic       s_axis_tlast,   // end_of_expression
  // Output request channel
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // [7:0] out_symbol
  output logic            m_axis_tlast,   // last
  output logic            m_axis_tuser    // [0] push_dropped
);

  // IDLE takes requests; POP compares the top entry whose read data arrived from the RAM
  // and pops it or pushes or drops the operator; PUSH finishes an operator on an empty stack.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PUSH
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             flush_q, flush_d;
  op_e              op_q, op_d;
  // An operator's pops are held back one step so the final one can be
  // tagged last once the push or drop decision is known.
  logic             pend_valid_q, pend_valid_d;
  logic [7:0]       pend_sym_q, pend_sym_d;
  // Output register: parts the output handshake from the controller.
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_sym_q, out_sym_d;
  logic             out_last_q, out_last_d;
  logic             out_drop_q, out_drop_d;

  logic             s_acc;
  logic             out_free;
  logic             emit;
  logic [7:0]       emit_sym;
  logic             emit_last;
  logic             emit_drop;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] cnt_dec2;
  logic             can_push;
  logic             pend_ok;
  logic             pop_hit;

  logic             ram_we;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [OP_W-1:0]  ram_rdata;
  op_e              top_op;

  itp_ram #(
    .Width (OP_W),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[PTR_W-1:0]),
    .wdata_i (op_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign top_op   = op_e'(ram_rdata);
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign cnt_dec2 = cnt_q - CNT_W'(2);
  assign can_push = cnt_q < DEPTH_CNT;
  assign pend_ok  = !pend_valid_q || out_free;
  assign pop_hit  = flush_q || (top_op[OP_W-1] >= op_q[OP_W-1]);

  // Controller. The FSM never reads an entry in the same cycle it writes
  // one: the push ends the item and the next read comes with a new request,
  // so the RAM needs no forwarding path.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    flush_d      = flush_q;
    op_d         = op_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = cnt_dec[PTR_W-1:0];
    emit         = 1'b0;
    emit_sym     = pend_sym_q;
    emit_last    = 1'b0;
    emit_drop    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tlast) begin
            // Flush: start reading the top if there is one.
            if (cnt_q != '0) begin
              ram_re  = 1'b1;
              flush_d = 1'b1;
              state_d = ST_POP;
            end
          end else if (is_blank(s_axis_tdata)) begin
            // Drop blanks silently.
          end else if (is_op(s_axis_tdata)) begin
            op_d    = op_code(s_axis_tdata);
            flush_d = 1'b0;
            if (cnt_q == '0) begin
              state_d = ST_PUSH;
            end else begin
              ram_re  = 1'b1;
              state_d = ST_POP;
            end
          end else begin
            // Operand: pass straight to the output register.
            emit      = 1'b1;
            emit_sym  = s_axis_tdata;
            emit_last = 1'b1;
          end
        end
      end

      ST_POP: begin
        if (pop_hit && flush_q) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_sym  = op_char(top_op);
            emit_last = (cnt_q == CNT_W'(1));
            cnt_d     = cnt_dec;
            if (cnt_q == CNT_W'(1)) begin
              flush_d = 1'b0;
              state_d = ST_IDLE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_dec2[PTR_W-1:0];
            end
          end
        end else if (pop_hit) begin
          if (pend_ok) begin
            emit         = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_sym_d   = op_char(top_op);
            cnt_d        = cnt_dec;
            if (cnt_q == CNT_W'(1)) begin
              state_d = ST_PUSH;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_dec2[PTR_W-1:0];
            end
          end
        end else if (can_push) begin
          if (pend_ok) begin
            ram_we       = 1'b1;
            cnt_d        = cnt_q + CNT_W'(1);
            emit         = pend_valid_q;
            emit_last    = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else if (out_free) begin
          // Full stack with nothing popped: drop the operator.
          emit      = 1'b1;
          emit_sym  = op_char(op_q);
          emit_last = 1'b1;
          emit_drop = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      ST_PUSH: begin
        // Stack is empty here, so the push always fits.
        if (pend_ok) begin
          ram_we       = 1'b1;
          cnt_d        = cnt_q + CNT_W'(1);
          emit         = pend_valid_q;
          emit_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drain on the output handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_sym_d   = emit_sym;
      out_last_d  = emit_last;
      out_drop_d  = emit_drop;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      flush_q      <= 1'b0;
      op_q         <= OP_ADD;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      flush_q      <= flush_d;
      op_q         <= op_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sym_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_drop_q;

  // Stack count never runs past the RAM depth.
  `ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= DEPTH_CNT)
  // A dropped operator is always the final result of its request.
  `ASSERT_IMP(a_drop_last, clk_i, rst_ni, out_valid_q && out_drop_q, out_last_q)
  // No pop is left pending once the controller is back in idle.
  `ASSERT_IMP(a_pend_idle, clk_i, rst_ni, state_q == ST_IDLE, !pend_valid_q)
  // A flush never pushes.
  `ASSERT_IMP(a_flush_no_push, clk_i, rst_ni, ram_we, !flush_q)
  // A push grows the stack by exactly one.
  `ASSERT_NXT(a_push_grow, clk_i, rst_ni, ram_we, cnt_q == $past(cnt_q) + CNT_W'(1))

endmodule

`default_nettype wire

[hw/rtl/itp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module itp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Hold read data when no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[tb/sv/infix_to_postfix_converter_test.sv]
`timescale 1ns / 1ps

module infix_to_postfix_converter_test
  import itp_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_REQS  = 32;
  localparam int unsigned TAIL_CYCLES = 2 * STACK_DEPTH + 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       dropped;
  } postfix_char_t;

  // Tracks the operator stack and holds the postfix characters still owed by the block.
  class postfix_tracker;
    logic [OP_W-1:0] op_stack[STACK_DEPTH];
    int unsigned     depth;
    postfix_char_t   owed[$];
    postfix_char_t   held;
    bit              have_held;
    int unsigned     mismatches;
    int unsigned     requests_taken;
    int unsigned     chars_checked;
    int unsigned     operators_seen;
    int unsigned     flushes_seen;

    function new();
      depth          = 0;
      have_held      = 1'b0;
      mismatches     = 0;
      requests_taken = 0;
      chars_checked  = 0;
      operators_seen = 0;
      flushes_seen   = 0;
    endfunction

    function logic [7:0] glyph_of(logic [OP_W-1:0] code);
      logic [7:0] g;
      case (code)
        OP_ADD:  g = CH_PLUS;
        OP_SUB:  g = CH_MINUS;
        OP_MUL:  g = CH_MUL;
        default: g = CH_DIV;
      endcase
      return g;
    endfunction

    // Hold back one character so the final one of a request can carry last.
    function void owe(logic [7:0] ch, logic dropped);
      if (have_held) owed.push_back(held);
      held.ch      = ch;
      held.last    = 1'b0;
      held.dropped = dropped;
      have_held    = 1'b1;
    endfunction

    function void pop_top();
      depth--;
      owe(glyph_of(op_stack[depth]), 1'b0);
    endfunction

    function void take_symbol(logic [7:0] sym, logic eoe);
      logic [OP_W-1:0] code;
      bit              is_oper;
      requests_taken++;
      is_oper = 1'b1;
      code    = OP_ADD;
      if (eoe) begin
        flushes_seen++;
        while (depth > 0) pop_top();
      end else if (sym == CH_SPACE || sym == CH_TAB || sym == CH_NL) begin
        return;
      end else begin
        case (sym)
          CH_PLUS:  code = OP_ADD;
          CH_MINUS: code = OP_SUB;
          CH_MUL:   code = OP_MUL;
          CH_DIV:   code = OP_DIV;
          default:  is_oper = 1'b0;
        endcase
        if (!is_oper) begin
          owe(sym, 1'b0);
        end else begin
          operators_seen++;
          // The upper code bit is the precedence: pop equal or higher.
          while (depth > 0 && op_stack[depth-1][OP_W-1] >= code[OP_W-1]) pop_top();
          if (depth >= STACK_DEPTH) begin
            owe(sym, 1'b1);
          end else begin
            op_stack[depth] = code;
            depth++;
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        owed.push_back(held);
        have_held = 1'b0;
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    task check_emitted(logic [7:0] ch, logic last, logic dropped);
      postfix_char_t want;
      chars_checked++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%b dropped=%b",
                                  ch, last, dropped));
        return;
      end
      want = owed.pop_front();
      if (ch !== want.ch)
        report_mismatch($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, want %b (char 0x%02h)", last, want.last, want.ch));
      if (dropped !== want.dropped)
        report_mismatch($sformatf("dropped %b, want %b (char 0x%02h)",
                                  dropped, want.dropped, want.ch));
    endtask
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] symbol
  logic       s_axis_tlast  = 1'b0;    // end_of_expression
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] out_symbol
  logic       m_axis_tlast;            // last
  logic       m_axis_tuser;            // [0] push_dropped

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    cycle_count = 0;
  postfix_tracker tracker = new();

  infix_to_postfix_converter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_emitted(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Present one request, idling at random first, and note it once taken.
  task automatic send_request(input logic [7:0] sym, input logic eoe);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = sym;
    s_axis_tlast  = eoe;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.take_symbol(sym, eoe);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (tracker.owed.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] b;
    b = 8'($urandom_range(255, 0));
    while (b == CH_PLUS || b == CH_MINUS || b == CH_MUL || b == CH_DIV ||
           b == CH_SPACE || b == CH_TAB || b == CH_NL)
      b = 8'($urandom_range(255, 0));
    return b;
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] b;
    case ($urandom_range(3, 0))
      0:       b = CH_PLUS;
      1:       b = CH_MINUS;
      2:       b = CH_MUL;
      default: b = CH_DIV;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pick_blank();
    logic [7:0] b;
    case ($urandom_range(2, 0))
      0:       b = CH_SPACE;
      1:       b = CH_TAB;
      default: b = CH_NL;
    endcase
    return b;
  endfunction

  // Mostly well-formed expressions with random content; the rest is raw noise.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned stop_at;
    int unsigned n_operands;
    stop_at        = tracker.requests_taken + PHASE_REQS;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (tracker.requests_taken < stop_at) begin
      if ($urandom_range(99, 0) < 80) begin
        n_operands = $urandom_range(5, 1);
        for (int i = 0; i < n_operands; i++) begin
          if (i != 0) send_request(pick_operator(), 1'b0);
          if ($urandom_range(9, 0) == 0) send_request(pick_blank(), 1'b0);
          send_request(pick_operand(), 1'b0);
        end
        send_request(8'($urandom_range(255, 0)), 1'b1);
      end else begin
        send_request(8'($urandom_range(255, 0)), ($urandom_range(9, 0) == 0));
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Operand extremes, and a caret that is just an operand.
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request("^", 1'b0);
    // a + b * c with a trailing blank, then flush: a b c * +
    send_request("a", 1'b0);
    send_request(CH_PLUS, 1'b0);
    send_request("b", 1'b0);
    send_request(CH_MUL, 1'b0);
    send_request("c", 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(8'h00, 1'b1);
    // x * y - z / w + q with tab and newline, covering pops of both levels.
    send_request("x", 1'b0);
    send_request(CH_MUL, 1'b0);
    send_request("y", 1'b0);
    send_request(CH_TAB, 1'b0);
    send_request(CH_MINUS, 1'b0);
    send_request("z", 1'b0);
    send_request(CH_DIV, 1'b0);
    send_request("w", 1'b0);
    send_request(CH_NL, 1'b0);
    send_request(CH_PLUS, 1'b0);
    send_request("q", 1'b0);
    send_request(8'hFF, 1'b1);
    // Flush of an empty stack; the operator byte on it must be ignored.
    send_request(CH_MUL, 1'b1);
    wait_drained();

    run_phase(0, 0);
    run_phase(61, 0);
    run_phase(0, 61);
    run_phase(19, 19);

    recv_stall_pct = 0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.owed.size() != 0)
      tracker.report_mismatch($sformatf("%0d postfix chars never emitted",
                                        tracker.owed.size()));

    $display("Covered %0d requests (%0d operators, %0d flushes), %0d postfix chars checked",
             tracker.requests_taken, tracker.operators_seen, tracker.flushes_seen,
             tracker.chars_checked);
    $display("Idle/stall mixes: none, sender-heavy, receiver-heavy, both; %0d mismatches",
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
